// ----- sv/cspt_pkg.sv -----
// cspt_pkg: shared constants, register codes and types of the collinear segment pair test
// no dependencies; imported by cspt_geom, cspt_tests and collinear_segment_pair_test
`timescale 1ns / 1ps

package cspt_pkg;

	// geometry and fixed-point layout
	localparam int COORD_BITS_DEF = 16;
	localparam int FIELD_W        = 16;
	localparam int Q_SHIFT        = 16;
	localparam int NUM_COORDS     = 8;

	// configuration port
	localparam int CFG_DATA_W = 18;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_COS_SQ     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERP_TOL   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALONG_LOW  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALONG_HIGH = 2'd3;

	// register reset values
	localparam logic [15:0]        COS_SQ_RST     = 16'd59146;
	localparam logic [15:0]        PERP_TOL_RST   = 16'd3277;
	localparam logic signed [17:0] ALONG_LOW_RST  = -18'sd13107;
	localparam logic signed [17:0] ALONG_HIGH_RST = 18'sd78643;

	// threshold registers as one group
	typedef struct packed {
		logic [15:0]        cos_sq;
		logic [15:0]        perp_tol;
		logic signed [17:0] along_low;
		logic signed [17:0] along_high;
	} cspt_cfg_t;

	// per-pair flags that travel with the data
	typedef struct packed {
		logic sec;   // second segment is the reference
		logic zero;  // one segment has zero length
	} cspt_flags_t;

endpackage

// ----- sv/cspt_mul.sv -----
// cspt_mul: two-stage unsigned multiplier built from four half-width partial products
// depends on nothing outside itself; used by cspt_tests for the angle test
`timescale 1ns / 1ps

module cspt_mul #(
	parameter int AW = 33,
	parameter int BW = 33
) (
	input  logic            clk,
	input  logic            en,
	input  logic [AW-1:0]   a,
	input  logic [BW-1:0]   b,
	output logic [AW+BW-1:0] prod
);

	localparam int AL = (AW + 1) / 2;
	localparam int AU = AW - AL;
	localparam int BL = (BW + 1) / 2;
	localparam int BU = BW - BL;
	localparam int PW = AW + BW;

	logic [AL+BL-1:0] p00_s1;
	logic [AL+BU-1:0] p01_s1;
	logic [AU+BL-1:0] p10_s1;
	logic [AU+BU-1:0] p11_s1;
	logic [PW-1:0]    prod_s2;

	// partial products
	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= a[AL-1:0] * b[BL-1:0];
			p01_s1 <= a[AL-1:0] * b[BW-1:BL];
			p10_s1 <= a[AW-1:AL] * b[BL-1:0];
			p11_s1 <= a[AW-1:AL] * b[BW-1:BL];
		end
	end

	// weighted sum of the partial products
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= (PW'(p11_s1) << (AL + BL)) + (PW'(p10_s1) << AL)
				+ (PW'(p01_s1) << BL) + PW'(p00_s1);
		end
	end

	assign prod = prod_s2;

endmodule

// ----- sv/cspt_geom.sv -----
// cspt_geom: stages 1 to 4, differences, squared lengths, dot product and reference frame
// depends on cspt_pkg
`timescale 1ns / 1ps

module cspt_geom import cspt_pkg::*; #(
	parameter int CB = COORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [FIELD_W-1:0]     coord [NUM_COORDS],
	input  cspt_cfg_t              cfg,
	output logic                   v_s4,
	output cspt_flags_t            flags_s4,
	output logic signed [CB:0]     dx_s4,
	output logic signed [CB:0]     dy_s4,
	output logic signed [CB:0]     vx_s4 [2],
	output logic signed [CB:0]     vy_s4 [2],
	output logic [2*CB:0]          lr_s4,
	output logic [2*CB:0]          lb_s4,
	output logic [2*CB:0]          dmag_s4,
	output logic [2*CB+16:0]       cos_la_s4
);

	localparam int LW = 2 * CB + 1;

	function automatic logic signed [CB:0] sub(input logic [CB-1:0] a, input logic [CB-1:0] b);
		return $signed({1'b0, a}) - $signed({1'b0, b});
	endfunction

	function automatic logic signed [2*CB:0] smul(input logic signed [CB:0] a,
			input logic signed [CB:0] b);
		logic signed [2*CB+1:0] p;
		p = a * b;
		return p[2*CB:0];
	endfunction

	logic [CB-1:0] c [NUM_COORDS];

	logic v_s1, v_s2, v_s3;
	logic signed [CB:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic signed [CB:0] ax_s2, ay_s2, bx_s2, by_s2;
	logic signed [CB:0] ax_s3, ay_s3, bx_s3, by_s3;
	logic signed [CB:0] fo_x_s1 [2], fo_y_s1 [2], so_x_s1 [2], so_y_s1 [2];
	logic signed [CB:0] fo_x_s2 [2], fo_y_s2 [2], so_x_s2 [2], so_y_s2 [2];
	logic signed [CB:0] fo_x_s3 [2], fo_y_s3 [2], so_x_s3 [2], so_y_s3 [2];
	logic [2*CB-1:0] ax2_s2, ay2_s2, bx2_s2, by2_s2;
	logic signed [2*CB:0] abx_s2, aby_s2;
	logic signed [2*CB:0] ax2_w, ay2_w, bx2_w, by2_w;
	logic [LW-1:0] la_s3, lb_s3;
	logic signed [2*CB+1:0] dot_s3;
	logic signed [2*CB+1:0] dmag_w;
	logic sec_w;

	// low coordinate bits in use
	always_comb begin
		for (int i = 0; i < NUM_COORDS; i++) begin
			c[i] = CB'(coord[i]);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: directions and endpoint offsets for both possible frames
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1      <= sub(c[2], c[0]);
			ay_s1      <= sub(c[3], c[1]);
			bx_s1      <= sub(c[6], c[4]);
			by_s1      <= sub(c[7], c[5]);
			fo_x_s1[0] <= sub(c[4], c[0]);
			fo_y_s1[0] <= sub(c[5], c[1]);
			fo_x_s1[1] <= sub(c[6], c[0]);
			fo_y_s1[1] <= sub(c[7], c[1]);
			so_x_s1[0] <= sub(c[0], c[4]);
			so_y_s1[0] <= sub(c[1], c[5]);
			so_x_s1[1] <= sub(c[2], c[4]);
			so_y_s1[1] <= sub(c[3], c[5]);
		end
	end

	// stage 2: squares and dot product terms
	always_comb begin
		ax2_w = smul(ax_s1, ax_s1);
		ay2_w = smul(ay_s1, ay_s1);
		bx2_w = smul(bx_s1, bx_s1);
		by2_w = smul(by_s1, by_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax2_s2  <= ax2_w[2*CB-1:0];
			ay2_s2  <= ay2_w[2*CB-1:0];
			bx2_s2  <= bx2_w[2*CB-1:0];
			by2_s2  <= by2_w[2*CB-1:0];
			abx_s2  <= smul(ax_s1, bx_s1);
			aby_s2  <= smul(ay_s1, by_s1);
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			bx_s2   <= bx_s1;
			by_s2   <= by_s1;
			fo_x_s2 <= fo_x_s1;
			fo_y_s2 <= fo_y_s1;
			so_x_s2 <= so_x_s1;
			so_y_s2 <= so_y_s1;
		end
	end

	// stage 3: squared lengths and dot product
	always_ff @(posedge clk) begin
		if (en) begin
			la_s3   <= {1'b0, ax2_s2} + {1'b0, ay2_s2};
			lb_s3   <= {1'b0, bx2_s2} + {1'b0, by2_s2};
			dot_s3  <= {abx_s2[2*CB], abx_s2} + {aby_s2[2*CB], aby_s2};
			ax_s3   <= ax_s2;
			ay_s3   <= ay_s2;
			bx_s3   <= bx_s2;
			by_s3   <= by_s2;
			fo_x_s3 <= fo_x_s2;
			fo_y_s3 <= fo_y_s2;
			so_x_s3 <= so_x_s2;
			so_y_s3 <= so_y_s2;
		end
	end

	// stage 4: pick the longer segment as frame, ties keep the first
	always_comb begin
		sec_w  = lb_s3 > la_s3;
		dmag_w = dot_s3[2*CB+1] ? -dot_s3 : dot_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s4.sec  <= sec_w;
			flags_s4.zero <= (la_s3 == '0) || (lb_s3 == '0);
			dx_s4         <= sec_w ? bx_s3 : ax_s3;
			dy_s4         <= sec_w ? by_s3 : ay_s3;
			lr_s4         <= sec_w ? lb_s3 : la_s3;
			for (int i = 0; i < 2; i++) begin
				vx_s4[i] <= sec_w ? so_x_s3[i] : fo_x_s3[i];
				vy_s4[i] <= sec_w ? so_y_s3[i] : fo_y_s3[i];
			end
			lb_s4         <= lb_s3;
			dmag_s4       <= dmag_w[2*CB:0];
			cos_la_s4     <= cfg.cos_sq * la_s3;
		end
	end

endmodule

// ----- sv/cspt_tests.sv -----
// cspt_tests: stages 5 to 7, angle, offset and overlap tests and the output register
// depends on cspt_pkg and cspt_mul
`timescale 1ns / 1ps

module cspt_tests import cspt_pkg::*; #(
	parameter int CB = COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  cspt_cfg_t          cfg,
	input  logic               v_s4,
	input  cspt_flags_t        flags_s4,
	input  logic signed [CB:0] dx_s4,
	input  logic signed [CB:0] dy_s4,
	input  logic signed [CB:0] vx_s4 [2],
	input  logic signed [CB:0] vy_s4 [2],
	input  logic [2*CB:0]      lr_s4,
	input  logic [2*CB:0]      lb_s4,
	input  logic [2*CB:0]      dmag_s4,
	input  logic [2*CB+16:0]   cos_la_s4,
	output logic               out_valid,
	output logic               linked,
	output logic               angle_ok,
	output logic               offset_ok,
	output logic               overlap_ok,
	output logic               second_is_reference
);

	localparam int LW  = 2 * CB + 1;
	localparam int CLW = LW + 16;
	localparam int THW = CLW + LW;
	localparam int SW  = 2 * CB + 19;

	function automatic logic signed [2*CB:0] smul(input logic signed [CB:0] a,
			input logic signed [CB:0] b);
		logic signed [2*CB+1:0] p;
		p = a * b;
		return p[2*CB:0];
	endfunction

	function automatic logic signed [SW-1:0] bound(input logic signed [17:0] a,
			input logic [LW-1:0] l);
		logic signed [SW:0] p;
		p = $signed(a) * $signed({1'b0, l});
		return p[SW-1:0];
	endfunction

	logic v_s5, v_s6;
	cspt_flags_t flags_s5, flags_s6;
	logic signed [2*CB:0] ad_s5 [2], bd_s5 [2], pa_s5 [2], pb_s5 [2];
	logic [CLW-1:0] tol_lr_s5, tol_lr_s6;
	logic signed [SW-1:0] low_lr_s5, low_lr_s6, high_lr_s5, high_lr_s6;
	logic signed [2*CB+1:0] along_s6 [2], perp_s6 [2];
	logic [2*LW-1:0] dsq_s6;
	logic [THW-1:0] thr_s6;

	logic signed [2*CB+1:0] perp_abs_w [2];
	logic [CLW-1:0] perp_scaled_w [2];
	logic signed [SW-1:0] along_scaled_w [2];
	logic [1:0] in_tol_w, above_w, below_w;
	logic angle_w, offset_w, overlap_w;

	// angle test products, two stages each, in step with stages 5 and 6
	cspt_mul #(.AW(LW), .BW(LW)) u_dot_sq (
		.clk  (clk),
		.en   (en),
		.a    (dmag_s4),
		.b    (dmag_s4),
		.prod (dsq_s6)
	);

	cspt_mul #(.AW(CLW), .BW(LW)) u_len_thr (
		.clk  (clk),
		.en   (en),
		.a    (cos_la_s4),
		.b    (lb_s4),
		.prod (thr_s6)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			out_valid <= v_s6;
		end
	end

	// stage 5: projection products and length-scaled thresholds
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				ad_s5[i] <= smul(vx_s4[i], dx_s4);
				bd_s5[i] <= smul(vy_s4[i], dy_s4);
				pa_s5[i] <= smul(vx_s4[i], dy_s4);
				pb_s5[i] <= smul(vy_s4[i], dx_s4);
			end
			tol_lr_s5  <= cfg.perp_tol * lr_s4;
			low_lr_s5  <= bound(cfg.along_low, lr_s4);
			high_lr_s5 <= bound(cfg.along_high, lr_s4);
			flags_s5   <= flags_s4;
		end
	end

	// stage 6: along-line and perpendicular positions
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				along_s6[i] <= {ad_s5[i][2*CB], ad_s5[i]} + {bd_s5[i][2*CB], bd_s5[i]};
				perp_s6[i]  <= {pa_s5[i][2*CB], pa_s5[i]} - {pb_s5[i][2*CB], pb_s5[i]};
			end
			tol_lr_s6  <= tol_lr_s5;
			low_lr_s6  <= low_lr_s5;
			high_lr_s6 <= high_lr_s5;
			flags_s6   <= flags_s5;
		end
	end

	// stage 7: compares against the scaled thresholds
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			perp_abs_w[i]     = perp_s6[i][2*CB+1] ? -perp_s6[i] : perp_s6[i];
			perp_scaled_w[i]  = {perp_abs_w[i][2*CB:0], {Q_SHIFT{1'b0}}};
			along_scaled_w[i] = $signed({along_s6[i][2*CB+1], along_s6[i], {Q_SHIFT{1'b0}}});
			in_tol_w[i]       = perp_scaled_w[i] < tol_lr_s6;
			above_w[i]        = along_scaled_w[i] > low_lr_s6;
			below_w[i]        = along_scaled_w[i] < high_lr_s6;
		end
		angle_w   = !flags_s6.zero && ({dsq_s6, {Q_SHIFT{1'b0}}} >= thr_s6);
		offset_w  = !flags_s6.zero && (&in_tol_w);
		overlap_w = !flags_s6.zero && (|above_w) && (|below_w);
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			angle_ok            <= angle_w;
			offset_ok           <= offset_w;
			overlap_ok          <= overlap_w;
			linked              <= angle_w && offset_w && overlap_w;
			second_is_reference <= flags_s6.sec;
		end
	end

endmodule

// ----- sv/collinear_segment_pair_test.sv -----
// collinear_segment_pair_test: top level, threshold registers, pipeline enable and stages
// depends on cspt_pkg, cspt_geom, cspt_tests (and through it cspt_mul)
//
//  channel  direction  handshake              payload
//  in       into block in_valid / in_stall    first_*, second_* endpoint coordinates
//  out      from block out_valid / out_stall  linked, angle_ok, offset_ok, overlap_ok,
//                                             second_is_reference
//  cfg      into block cfg_we                 cfg_index, cfg_data
//
// one segment pair per cycle unless a stall holds the pipeline; a result passes through
// the seven register stages, of which the angle test's split wide multipliers take two.
// reset loads the threshold registers with their defaults and clears all valid bits.
// out_stall with a result waiting freezes every stage at once, and in_stall follows it.
`timescale 1ns / 1ps

module collinear_segment_pair_test import cspt_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [FIELD_W-1:0]    first_start_x,
	input  logic [FIELD_W-1:0]    first_start_y,
	input  logic [FIELD_W-1:0]    first_end_x,
	input  logic [FIELD_W-1:0]    first_end_y,
	input  logic [FIELD_W-1:0]    second_start_x,
	input  logic [FIELD_W-1:0]    second_start_y,
	input  logic [FIELD_W-1:0]    second_end_x,
	input  logic [FIELD_W-1:0]    second_end_y,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  linked,
	output logic                  angle_ok,
	output logic                  offset_ok,
	output logic                  overlap_ok,
	output logic                  second_is_reference,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CB = COORD_BITS;

	cspt_cfg_t cfg_q;
	logic en;
	logic [FIELD_W-1:0] coord [NUM_COORDS];

	logic               v_s4;
	cspt_flags_t        flags_s4;
	logic signed [CB:0] dx_s4, dy_s4;
	logic signed [CB:0] vx_s4 [2], vy_s4 [2];
	logic [2*CB:0]      lr_s4, lb_s4, dmag_s4;
	logic [2*CB+16:0]   cos_la_s4;

	// threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cos_sq     <= COS_SQ_RST;
			cfg_q.perp_tol   <= PERP_TOL_RST;
			cfg_q.along_low  <= ALONG_LOW_RST;
			cfg_q.along_high <= ALONG_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COS_SQ:     cfg_q.cos_sq     <= cfg_data[15:0];
				REG_PERP_TOL:   cfg_q.perp_tol   <= cfg_data[15:0];
				REG_ALONG_LOW:  cfg_q.along_low  <= $signed(cfg_data[17:0]);
				REG_ALONG_HIGH: cfg_q.along_high <= $signed(cfg_data[17:0]);
				default: ;
			endcase
		end
	end

	// whole pipeline advances unless a waiting result is held back
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	assign coord[0] = first_start_x;
	assign coord[1] = first_start_y;
	assign coord[2] = first_end_x;
	assign coord[3] = first_end_y;
	assign coord[4] = second_start_x;
	assign coord[5] = second_start_y;
	assign coord[6] = second_end_x;
	assign coord[7] = second_end_y;

	// stages 1 to 4
	cspt_geom #(.CB(CB)) u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.coord     (coord),
		.cfg       (cfg_q),
		.v_s4      (v_s4),
		.flags_s4  (flags_s4),
		.dx_s4     (dx_s4),
		.dy_s4     (dy_s4),
		.vx_s4     (vx_s4),
		.vy_s4     (vy_s4),
		.lr_s4     (lr_s4),
		.lb_s4     (lb_s4),
		.dmag_s4   (dmag_s4),
		.cos_la_s4 (cos_la_s4)
	);

	// stages 5 to 7
	cspt_tests #(.CB(CB)) u_tests (
		.clk                 (clk),
		.arst_n              (arst_n),
		.en                  (en),
		.cfg                 (cfg_q),
		.v_s4                (v_s4),
		.flags_s4            (flags_s4),
		.dx_s4               (dx_s4),
		.dy_s4               (dy_s4),
		.vx_s4               (vx_s4),
		.vy_s4               (vy_s4),
		.lr_s4               (lr_s4),
		.lb_s4               (lb_s4),
		.dmag_s4             (dmag_s4),
		.cos_la_s4           (cos_la_s4),
		.out_valid           (out_valid),
		.linked              (linked),
		.angle_ok            (angle_ok),
		.offset_ok           (offset_ok),
		.overlap_ok          (overlap_ok),
		.second_is_reference (second_is_reference)
	);

endmodule
